// File: rtl/qte_pkg.sv
// Shared types, constants and helper functions of the quaternion-to-trimmed-Euler core.
// Used by the front end, the item queue, the back end and the top level.
// No dependencies.
package qte_pkg;

   localparam int CORDIC_STEPS_DFLT = 16;
   localparam int QUEUE_DEPTH_DFLT  = 2;
   localparam int CNT_W             = 5;

   // Report codes in the mode field.
   localparam logic [2:0] MODE_ROT  = 3'd0;
   localparam logic [2:0] MODE_GYRO = 3'd1;
   localparam logic [2:0] MODE_ZERO = 3'd3;
   localparam logic [2:0] MODE_LOAD = 3'd4;

   // Angle selector of the shared CORDIC unit.
   localparam logic [1:0] ANG_YAW   = 2'd0;
   localparam logic [1:0] ANG_PITCH = 2'd1;
   localparam logic [1:0] ANG_ROLL  = 2'd2;

   // Last step indexes of the multiply sequence and the square root.
   localparam logic [CNT_W-1:0] MUL_LAST  = 5'd12;
   localparam logic [CNT_W-1:0] SQRT_LAST = 5'd30;
   localparam logic [5:0]       SQRT_TOP  = 6'd60;
   localparam int               SQ_W      = 62;

   localparam logic signed [31:0] DEG90     = 32'sd589824000;
   localparam logic signed [20:0] RATE_GAIN = 21'sd733386;

   typedef enum logic [2:0] {
      OP_ROT,
      OP_GYRO,
      OP_ZERO,
      OP_LOAD,
      OP_NOP
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SQRT,
      ST_CINIT,
      ST_CITER,
      ST_POST1,
      ST_POST2,
      ST_APPLY,
      ST_OUT
   } st_type;

   typedef struct packed {
      op_type             op;
      logic signed [15:0] quat_i;
      logic signed [15:0] quat_j;
      logic signed [15:0] quat_k;
      logic signed [15:0] quat_real;
      logic signed [15:0] gyro;
      logic [1:0]         accuracy;
      logic signed [15:0] trim_pitch;
      logic signed [15:0] trim_roll;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   // Arctangent of 2^-i in centidegrees scaled by 65536.
   function automatic logic [28:0] atan_entry(input logic [CNT_W-1:0] idx);
      logic [28:0] v;
      case (idx)
         5'd0:    v = 29'd294912000;
         5'd1:    v = 29'd174096719;
         5'd2:    v = 29'd91987925;
         5'd3:    v = 29'd46694507;
         5'd4:    v = 29'd23437865;
         5'd5:    v = 29'd11730358;
         5'd6:    v = 29'd5866610;
         5'd7:    v = 29'd2933484;
         5'd8:    v = 29'd1466764;
         5'd9:    v = 29'd733385;
         5'd10:   v = 29'd366693;
         5'd11:   v = 29'd183346;
         5'd12:   v = 29'd91673;
         5'd13:   v = 29'd45837;
         5'd14:   v = 29'd22918;
         5'd15:   v = 29'd11459;
         5'd16:   v = 29'd5730;
         5'd17:   v = 29'd2865;
         5'd18:   v = 29'd1432;
         5'd19:   v = 29'd716;
         5'd20:   v = 29'd358;
         5'd21:   v = 29'd179;
         5'd22:   v = 29'd90;
         5'd23:   v = 29'd45;
         default: v = 29'd0;
      endcase
      return v;
   endfunction

   // Wraps an angle into -18000..17999 centidegrees.
   function automatic logic signed [15:0] wrap180(input logic signed [19:0] a);
      logic signed [19:0] v;
      v = a + 20'sd18000;
      if (v < 0) begin
         v = v + 20'sd36000;
      end else if (v >= 20'sd36000) begin
         v = v - 20'sd36000;
      end
      return 16'(v - 20'sd18000);
   endfunction

endpackage

// File: rtl/qte_req_if.sv
// Request channel of the quaternion-to-trimmed-Euler core: one sensor report per beat.
// No dependencies.
interface qte_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic signed [15:0] quat_i;
   logic signed [15:0] quat_j;
   logic signed [15:0] quat_k;
   logic signed [15:0] quat_real;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;
   logic [7:0]         report_status;
   logic signed [15:0] trim_pitch_in;
   logic signed [15:0] trim_roll_in;

   modport source (
      output valid, mode, quat_i, quat_j, quat_k, quat_real, gyro_y, gyro_z,
             report_status, trim_pitch_in, trim_roll_in,
      input  ready
   );
   modport sink (
      input  valid, mode, quat_i, quat_j, quat_k, quat_real, gyro_y, gyro_z,
             report_status, trim_pitch_in, trim_roll_in,
      output ready
   );
endinterface

// File: rtl/qte_rsp_if.sv
// Response channel of the quaternion-to-trimmed-Euler core: one result per beat.
// No dependencies.
interface qte_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        yaw_out;
   logic signed [15:0] pitch_out;
   logic signed [15:0] roll_out;
   logic signed [19:0] yaw_rate_out;
   logic [1:0]         accuracy_out;
   logic               trim_captured;
   logic signed [15:0] trim_pitch_out;
   logic signed [15:0] trim_roll_out;

   modport source (
      output valid, yaw_out, pitch_out, roll_out, yaw_rate_out, accuracy_out,
             trim_captured, trim_pitch_out, trim_roll_out,
      input  ready
   );
   modport sink (
      input  valid, yaw_out, pitch_out, roll_out, yaw_rate_out, accuracy_out,
             trim_captured, trim_pitch_out, trim_roll_out,
      output ready
   );
endinterface

// File: rtl/quaternion_to_trimmed_euler_core.sv
// Top level of the quaternion-to-trimmed-Euler core: mount register, front end, queue, back end.
// Depends on qte_pkg, qte_req_if, qte_rsp_if, qte_front, qte_queue and qte_back.
//
// Every request beat is one sensor report and yields exactly one response beat carrying
// the current yaw, trimmed pitch and roll, yaw rate, accuracy and trim. A rotation report
// runs through the single shared 32x32 multiplier, the one-bit-per-cycle square root and
// three passes of the one CORDIC unit for yaw, pitch and roll. Gyro, zero-request, trim-load
// and ignored reports go from the queue through the apply state to the response. A queue of
// QUEUE_DEPTH reports lets new requests be taken while the back end is busy. A response
// register holds each result, and the next report leaves the queue only once that register
// is empty or being taken. The mount register is written through csr_wr_en and csr_wr_data
// and should change only while the core is idle.
module quaternion_to_trimmed_euler_core #(
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DFLT,
   parameter int QUEUE_DEPTH  = qte_pkg::QUEUE_DEPTH_DFLT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data,
   qte_req_if.sink   req_ch,
   qte_rsp_if.source rsp_ch
);
   import qte_pkg::*;

   logic       mount_ff;
   logic       q_push, q_pop;
   item_type   push_item, head_item;
   q_stat_type q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         mount_ff <= 1'b0;
      end else if (csr_wr_en) begin
         mount_ff <= csr_wr_data;
      end
   end

   qte_front u_front (
      .clock          (clock),
      .reset          (reset),
      .mount_vertical (mount_ff),
      .req_ch         (req_ch),
      .q_stat         (q_stat),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   qte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   qte_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .mount_vertical (mount_ff),
      .q_item         (head_item),
      .q_stat         (q_stat),
      .q_pop          (q_pop),
      .rsp_ch         (rsp_ch)
   );

endmodule

// File: rtl/qte_front.sv
// Front end: takes request beats, decodes the report type and picks the gyro axis.
// Depends on qte_pkg and qte_req_if.
module qte_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   mount_vertical,
   qte_req_if.sink                req_ch,
   input  qte_pkg::q_stat_type    q_stat,
   output logic                   q_push,
   output qte_pkg::item_type      q_item
);
   import qte_pkg::*;

   op_type op;

   always_comb begin
      unique case (req_ch.mode)
         MODE_ROT:  op = OP_ROT;
         MODE_GYRO: op = OP_GYRO;
         MODE_ZERO: op = OP_ZERO;
         MODE_LOAD: op = OP_LOAD;
         default:   op = OP_NOP;
      endcase
   end

   assign req_ch.ready = !q_stat.full;
   assign q_push       = req_ch.valid && !q_stat.full;

   always_comb begin
      q_item.op         = op;
      q_item.quat_i     = req_ch.quat_i;
      q_item.quat_j     = req_ch.quat_j;
      q_item.quat_k     = req_ch.quat_k;
      q_item.quat_real  = req_ch.quat_real;
      q_item.gyro       = mount_vertical ? req_ch.gyro_y : req_ch.gyro_z;
      q_item.accuracy   = req_ch.report_status[1:0];
      q_item.trim_pitch = req_ch.trim_pitch_in;
      q_item.trim_roll  = req_ch.trim_roll_in;
   end

   // A push never lands on a full queue.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full) else $error("push while queue full");
   // Ready follows the queue space alone.
   a_ready_space: assert property (@(posedge clock) disable iff (reset)
      !q_stat.full |-> req_ch.ready) else $error("ready low with queue space");
   // With a vertical mount, a stored gyro value is the y axis chosen by the mount.
   a_gyro_axis: assert property (@(posedge clock) disable iff (reset)
      (q_push && mount_vertical) |-> q_item.gyro == req_ch.gyro_y)
      else $error("wrong gyro axis");

endmodule

// File: rtl/qte_queue.sv
// Short FIFO of decoded reports between the front end and the back end.
// Depends on qte_pkg.
module qte_queue #(
   parameter int DEPTH = qte_pkg::QUEUE_DEPTH_DFLT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qte_pkg::item_type   push_item,
   input  logic                pop,
   output qte_pkg::item_type   head_item,
   output qte_pkg::q_stat_type stat
);
   import qte_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item  = entry_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(DEPTH));

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("queue count overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0) else $error("pop from empty queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule

// File: rtl/qte_back.sv
// Back end: runs one report at a time (rotations through a shared multiplier, a bit-serial
// square root and one CORDIC unit), keeps the orientation state and drives the response.
// Depends on qte_pkg and qte_rsp_if.
module qte_back #(
   parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DFLT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                mount_vertical,
   input  qte_pkg::item_type   q_item,
   input  qte_pkg::q_stat_type q_stat,
   output logic                q_pop,
   qte_rsp_if.source           rsp_ch
);
   import qte_pkg::*;

   localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
   localparam logic [SQ_W-1:0]  SQ_ONE      = SQ_W'(1);

   st_type             state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]         sel_ff;
   item_type           cur_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p, prod_ff;
   logic [28:0]        sq_ff [4];
   logic signed [30:0] pacc_ff, yacc_ff, racc_ff;
   logic [30:0]        n_ff;
   logic [60:0]        n2_ff;
   logic [60:0]        p2;

   logic [SQ_W-1:0]    rad_ff, root_ff;
   logic [SQ_W-1:0]    sq_bit, sq_try;

   logic signed [33:0] s0, s1, s2, s3;
   logic signed [33:0] ix, iy, x0, y0;
   logic signed [31:0] z0;
   logic signed [33:0] cx_ff, cy_ff, nx, ny;
   logic signed [31:0] cz_ff, nz, zr, atan_s;
   logic signed [15:0] res_ff [3];

   logic signed [17:0] yaw_t;
   logic signed [15:0] pw_ff, rw_ff;
   logic signed [35:0] gyro_prod;
   logic signed [35:0] gyro_rnd;

   logic [15:0]        yaw_angle_ff;
   logic signed [15:0] pitch_angle_ff, roll_angle_ff;
   logic signed [19:0] yaw_rate_ff;
   logic [1:0]         acc_ff;
   logic signed [15:0] pitch_trim_ff, roll_trim_ff;
   logic               zp_ff, cap_ff;

   logic               rsp_valid_ff;
   logic [15:0]        rsp_yaw_ff;
   logic signed [15:0] rsp_pitch_ff, rsp_roll_ff, rsp_tp_ff, rsp_tr_ff;
   logic signed [19:0] rsp_rate_ff;
   logic [1:0]         rsp_acc_ff;
   logic               rsp_cap_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               state_in = (q_item.op == OP_ROT) ? ST_MUL : ST_APPLY;
            end
         end
         ST_MUL: begin
            if (cnt_ff == MUL_LAST) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (cnt_ff == SQRT_LAST) state_in = ST_CINIT;
         end
         ST_CINIT: state_in = ST_CITER;
         ST_CITER: begin
            if (cnt_ff == CORDIC_LAST) begin
               state_in = (sel_ff == ANG_ROLL) ? ST_POST1 : ST_CINIT;
            end
         end
         ST_POST1: state_in = ST_POST2;
         ST_POST2: state_in = ST_OUT;
         ST_APPLY: state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the controller.
   always_comb begin
      q_pop = 1'b0;
      unique case (state_ff)
         ST_IDLE: q_pop = !q_stat.empty && (!rsp_valid_ff || rsp_ch.ready);
         default: q_pop = 1'b0;
      endcase
   end

   assign cnt_in = (state_in != state_ff) ? '0 : cnt_ff + 1'b1;

   // Multiplier operand sequence: squares, cross terms, then N*N and p*p.
   always_comb begin
      case (cnt_ff)
         5'd0:    begin mul_a = 32'(cur_ff.quat_i); mul_b = 32'(cur_ff.quat_i);    end
         5'd1:    begin mul_a = 32'(cur_ff.quat_j); mul_b = 32'(cur_ff.quat_j);    end
         5'd2:    begin mul_a = 32'(cur_ff.quat_k); mul_b = 32'(cur_ff.quat_k);    end
         5'd3:    begin mul_a = 32'(cur_ff.quat_real); mul_b = 32'(cur_ff.quat_real); end
         5'd4:    begin mul_a = 32'(cur_ff.quat_j); mul_b = 32'(cur_ff.quat_real); end
         5'd5:    begin mul_a = 32'(cur_ff.quat_i); mul_b = 32'(cur_ff.quat_k);    end
         5'd6:    begin mul_a = 32'(cur_ff.quat_i); mul_b = 32'(cur_ff.quat_j);    end
         5'd7:    begin mul_a = 32'(cur_ff.quat_k); mul_b = 32'(cur_ff.quat_real); end
         5'd8:    begin mul_a = 32'(cur_ff.quat_j); mul_b = 32'(cur_ff.quat_k);    end
         5'd9:    begin mul_a = 32'(cur_ff.quat_i); mul_b = 32'(cur_ff.quat_real); end
         5'd10:   begin mul_a = $signed({1'b0, n_ff}); mul_b = $signed({1'b0, n_ff}); end
         5'd11:   begin
            mul_a = $signed({pacc_ff, 1'b0});
            mul_b = $signed({pacc_ff, 1'b0});
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign p2    = prod_ff[60:0];

   // Square root, one result bit per cycle.
   assign sq_bit = SQ_ONE << (SQRT_TOP - {cnt_ff, 1'b0});
   assign sq_try = root_ff + sq_bit;

   // CORDIC start vector for the selected angle.
   assign s0 = $signed({5'b0, sq_ff[0]});
   assign s1 = $signed({5'b0, sq_ff[1]});
   assign s2 = $signed({5'b0, sq_ff[2]});
   assign s3 = $signed({5'b0, sq_ff[3]});

   always_comb begin
      case (sel_ff)
         ANG_YAW: begin
            ix = s0 - s1 - s2 + s3;
            iy = 34'($signed({yacc_ff, 1'b0}));
         end
         ANG_PITCH: begin
            ix = $signed({3'b0, root_ff[30:0]});
            iy = 34'($signed({pacc_ff, 1'b0}));
         end
         default: begin
            ix = s2 + s3 - s0 - s1;
            iy = 34'($signed({racc_ff, 1'b0}));
         end
      endcase
      // A vector in the left half plane is first turned by a quarter turn.
      if (ix < 0) begin
         if (iy >= 0) begin
            x0 = iy;
            y0 = -ix;
            z0 = DEG90;
         end else begin
            x0 = -iy;
            y0 = ix;
            z0 = -DEG90;
         end
      end else begin
         x0 = ix;
         y0 = iy;
         z0 = '0;
      end
   end

   // One vectoring step. Once y reaches zero the vector stays put.
   assign atan_s = $signed({3'b0, atan_entry(cnt_ff)});
   always_comb begin
      nx = cx_ff;
      ny = cy_ff;
      nz = cz_ff;
      if (cy_ff > 0) begin
         nx = cx_ff + (cy_ff >>> cnt_ff);
         ny = cy_ff - (cx_ff >>> cnt_ff);
         nz = cz_ff + atan_s;
      end else if (cy_ff < 0) begin
         nx = cx_ff - (cy_ff >>> cnt_ff);
         ny = cy_ff + (cx_ff >>> cnt_ff);
         nz = cz_ff - atan_s;
      end
   end
   assign zr = nz + 32'sd32768;

   assign yaw_t     = 18'(res_ff[ANG_YAW]) - 18'sd9000;
   assign gyro_prod = cur_ff.gyro * RATE_GAIN;
   assign gyro_rnd  = gyro_prod + 36'sd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         sel_ff         <= ANG_YAW;
         yaw_angle_ff   <= '0;
         pitch_angle_ff <= '0;
         roll_angle_ff  <= '0;
         yaw_rate_ff    <= '0;
         acc_ff         <= '0;
         pitch_trim_ff  <= '0;
         roll_trim_ff   <= '0;
         zp_ff          <= 1'b0;
         cap_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               sel_ff <= ANG_YAW;
               cap_ff <= 1'b0;
            end
            ST_CITER: begin
               if (cnt_ff == CORDIC_LAST) sel_ff <= sel_ff + 1'b1;
            end
            ST_POST1: begin
               if (yaw_t < 0) begin
                  yaw_angle_ff <= 16'(18'sd36000 - (yaw_t + 18'sd36000));
               end else begin
                  yaw_angle_ff <= 16'(18'sd36000 - yaw_t);
               end
               acc_ff <= cur_ff.accuracy;
            end
            ST_POST2: begin
               if (zp_ff) begin
                  zp_ff          <= 1'b0;
                  pitch_trim_ff  <= pw_ff;
                  roll_trim_ff   <= rw_ff;
                  pitch_angle_ff <= '0;
                  roll_angle_ff  <= '0;
                  cap_ff         <= 1'b1;
               end else begin
                  pitch_angle_ff <= wrap180(20'(pw_ff) - 20'(pitch_trim_ff));
                  roll_angle_ff  <= wrap180(20'(rw_ff) - 20'(roll_trim_ff));
               end
            end
            ST_APPLY: begin
               case (cur_ff.op)
                  OP_GYRO: yaw_rate_ff <= gyro_rnd[35:16];
                  OP_ZERO: zp_ff <= 1'b1;
                  OP_LOAD: begin
                     pitch_trim_ff <= cur_ff.trim_pitch;
                     roll_trim_ff  <= cur_ff.trim_roll;
                  end
                  default: ;
               endcase
            end
            ST_OUT: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // Datapath registers, no reset needed.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) cur_ff <= q_item;
         end
         ST_MUL: begin
            prod_ff <= mul_p;
            case (cnt_ff)
               5'd1:  sq_ff[0] <= prod_ff[28:0];
               5'd2:  sq_ff[1] <= prod_ff[28:0];
               5'd3:  sq_ff[2] <= prod_ff[28:0];
               5'd4:  sq_ff[3] <= prod_ff[28:0];
               5'd5: begin
                  pacc_ff <= prod_ff[30:0];
                  n_ff    <= 31'(sq_ff[0]) + 31'(sq_ff[1]) + 31'(sq_ff[2]) + 31'(sq_ff[3]);
               end
               5'd6:  pacc_ff <= pacc_ff - prod_ff[30:0];
               5'd7:  yacc_ff <= prod_ff[30:0];
               5'd8:  yacc_ff <= yacc_ff + prod_ff[30:0];
               5'd9:  racc_ff <= prod_ff[30:0];
               5'd10: racc_ff <= racc_ff + prod_ff[30:0];
               5'd11: n2_ff <= prod_ff[60:0];
               5'd12: begin
                  rad_ff  <= (p2 >= n2_ff) ? '0 : SQ_W'(n2_ff - p2);
                  root_ff <= '0;
               end
               default: ;
            endcase
         end
         ST_SQRT: begin
            if (rad_ff >= sq_try) begin
               rad_ff  <= rad_ff - sq_try;
               root_ff <= (root_ff >> 1) + sq_bit;
            end else begin
               root_ff <= root_ff >> 1;
            end
         end
         ST_CINIT: begin
            cx_ff <= x0;
            cy_ff <= y0;
            cz_ff <= z0;
         end
         ST_CITER: begin
            cx_ff <= nx;
            cy_ff <= ny;
            cz_ff <= nz;
            if (cnt_ff == CORDIC_LAST) res_ff[sel_ff] <= zr[31:16];
         end
         ST_POST1: begin
            pw_ff <= wrap180(-20'(res_ff[ANG_PITCH]));
            rw_ff <= wrap180(20'(res_ff[ANG_ROLL]) + (mount_vertical ? -20'sd9000
                                                                      : 20'sd18000));
         end
         ST_OUT: begin
            rsp_yaw_ff   <= yaw_angle_ff;
            rsp_pitch_ff <= pitch_angle_ff;
            rsp_roll_ff  <= roll_angle_ff;
            rsp_rate_ff  <= yaw_rate_ff;
            rsp_acc_ff   <= acc_ff;
            rsp_cap_ff   <= cap_ff;
            rsp_tp_ff    <= pitch_trim_ff;
            rsp_tr_ff    <= roll_trim_ff;
         end
         default: ;
      endcase
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.yaw_out        = rsp_yaw_ff;
   assign rsp_ch.pitch_out      = rsp_pitch_ff;
   assign rsp_ch.roll_out       = rsp_roll_ff;
   assign rsp_ch.yaw_rate_out   = rsp_rate_ff;
   assign rsp_ch.accuracy_out   = rsp_acc_ff;
   assign rsp_ch.trim_captured  = rsp_cap_ff;
   assign rsp_ch.trim_pitch_out = rsp_tp_ff;
   assign rsp_ch.trim_roll_out  = rsp_tr_ff;

   // The response register is always free when a result is written into it.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> !rsp_valid_ff) else $error("response overwritten");
   // A pending zero request is consumed by the rotation report that reaches it.
   a_zero_capture: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST2 && zp_ff) |=> (cap_ff && !zp_ff))
      else $error("zero request not captured");
   // A capturing beat reports zero pitch and roll.
   a_capture_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cap_ff) |-> (rsp_pitch_ff == '0 && rsp_roll_ff == '0))
      else $error("capture with nonzero angles");

endmodule

// File: bench/quaternion_to_trimmed_euler_core_test.sv
// Self-checking bench for quaternion_to_trimmed_euler_core: a directed table, then random reports.
// Depends on qte_pkg, qte_req_if, qte_rsp_if and the core itself.
`timescale 1ns / 100ps

module quaternion_to_trimmed_euler_core_test;
   import qte_pkg::*;

   localparam logic [2:0] MODE_GEOMAG   = 3'd2;
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam int         ANGLE_STEPS   = 16;
   localparam longint     QUARTER_TURN  = 64'sd589824000;
   localparam longint     RATE_SCALE    = 64'sd733386;
   localparam int         PHASE_ITEMS   = 360;

   localparam longint ARC_TAB [24] = '{
      294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
      5866610, 2933484, 1466764, 733385, 366693, 183346,
      91673, 45837, 22918, 11459, 5730, 2865,
      1432, 716, 358, 179, 90, 45};

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [15:0] quat_i;
      logic signed [15:0] quat_j;
      logic signed [15:0] quat_k;
      logic signed [15:0] quat_real;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic [7:0]         report_status;
      logic signed [15:0] trim_pitch_in;
      logic signed [15:0] trim_roll_in;
   } report_type;

   typedef struct packed {
      logic [15:0] yaw;
      logic [15:0] pitch;
      logic [15:0] roll;
      logic [19:0] rate;
      logic [1:0]  acc;
      logic        captured;
      logic [15:0] trim_pitch;
      logic [15:0] trim_roll;
   } attitude_type;

   typedef struct packed {
      report_type   rpt;
      logic         typed;
      attitude_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   qte_req_if req_bus ();
   qte_rsp_if rsp_bus ();

   quaternion_to_trimmed_euler_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus)
   );

   // Mirror of the core's state.
   logic vertical;
   int   m_yaw, m_pitch, m_roll, m_rate, m_pitch_trim, m_roll_trim;
   logic [1:0] m_acc;
   logic zero_armed;

   attitude_type pending_attitudes [$];
   int   errors;
   int   mismatches;
   int   stall_left;
   logic long_hold_req;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("[quaternion_to_trimmed_euler_core] ERROR");
      $finish;
   end

   function automatic int arc_cd(longint y, longint x);
      longint z, t, nx, ny;
      int i;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = QUARTER_TURN;
         end else begin
            x = -y; y = t; z = -QUARTER_TURN;
         end
      end
      for (i = 0; i < ANGLE_STEPS; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += ARC_TAB[i];
         end else if (y < 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= ARC_TAB[i];
         end else begin
            break;
         end
         x = nx; y = ny;
      end
      return int'((z + 32768) >>> 16);
   endfunction

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b; r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic int wrap_cd(int a);
      int x;
      x = (a + 18000) % 36000;
      if (x < 0) x += 36000;
      return x - 18000;
   endfunction

   function automatic attitude_type next_attitude(report_type r);
      longint qi, qj, qk, qr, ii, jj, kk, rr, n, p, g;
      longint unsigned n2, p2, root;
      int yaw, pitch, roll;
      attitude_type a;
      logic cap;
      qi = r.quat_i; qj = r.quat_j; qk = r.quat_k; qr = r.quat_real;
      cap = 1'b0;
      if (r.mode == MODE_ROT) begin
         ii = qi * qi; jj = qj * qj; kk = qk * qk; rr = qr * qr;
         n = ii + jj + kk + rr;
         p = 2 * (qj * qr - qi * qk);
         n2 = longint'(n) * longint'(n);
         p2 = (p < 0) ? -p : p;
         p2 = p2 * p2;
         root = (p2 >= n2) ? 0 : floor_root(n2 - p2);
         yaw   = arc_cd(2 * (qi * qj + qk * qr), ii - jj - kk + rr);
         pitch = arc_cd(p, longint'(root));
         roll  = arc_cd(2 * (qj * qk + qi * qr), -ii - jj + kk + rr);
         yaw -= 9000;
         if (yaw < 0) yaw += 36000;
         m_yaw = 36000 - yaw;
         roll += vertical ? -9000 : 18000;
         pitch = wrap_cd(-pitch);
         roll  = wrap_cd(roll);
         m_acc = r.report_status[1:0];
         if (zero_armed) begin
            zero_armed = 1'b0;
            m_pitch_trim = pitch;
            m_roll_trim = roll;
            m_pitch = 0;
            m_roll = 0;
            cap = 1'b1;
         end else begin
            m_pitch = wrap_cd(pitch - m_pitch_trim);
            m_roll  = wrap_cd(roll - m_roll_trim);
         end
      end else if (r.mode == MODE_GYRO) begin
         g = vertical ? longint'(r.gyro_y) : longint'(r.gyro_z);
         m_rate = int'((g * RATE_SCALE + 32768) >>> 16);
      end else if (r.mode == MODE_ZERO) begin
         zero_armed = 1'b1;
      end else if (r.mode == MODE_LOAD) begin
         m_pitch_trim = r.trim_pitch_in;
         m_roll_trim = r.trim_roll_in;
      end
      a.yaw = m_yaw[15:0];
      a.pitch = m_pitch[15:0];
      a.roll = m_roll[15:0];
      a.rate = m_rate[19:0];
      a.acc = m_acc;
      a.captured = cap;
      a.trim_pitch = m_pitch_trim[15:0];
      a.trim_roll = m_roll_trim[15:0];
      return a;
   endfunction

   // Each report is offered after a random gap and held until the core takes it.
   task automatic offer(report_type r, logic typed, attitude_type want);
      int gap;
      attitude_type a;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= r.mode;
      req_bus.quat_i        <= r.quat_i;
      req_bus.quat_j        <= r.quat_j;
      req_bus.quat_k        <= r.quat_k;
      req_bus.quat_real     <= r.quat_real;
      req_bus.gyro_y        <= r.gyro_y;
      req_bus.gyro_z        <= r.gyro_z;
      req_bus.report_status <= r.report_status;
      req_bus.trim_pitch_in <= r.trim_pitch_in;
      req_bus.trim_roll_in  <= r.trim_roll_in;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      a = next_attitude(r);
      pending_attitudes.push_back(typed ? want : a);
   endtask

   task automatic set_mount(logic v);
      req_bus.valid <= 1'b0;
      while (pending_attitudes.size() != 0) @(posedge clock);
      repeat (110) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      vertical = v;
   endtask

   function automatic logic signed [15:0] rand_quat();
      case ($urandom_range(0, 9))
         0:       return 16'sd0;
         1:       return 16'sd16384;
         2:       return -16'sd16384;
         3:       return 16'($signed($urandom_range(0, 200)) - 100);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic report_type rand_report();
      report_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)      r.mode = MODE_ROT;
      else if (pick < 70) r.mode = MODE_GYRO;
      else if (pick < 78) r.mode = MODE_ZERO;
      else if (pick < 86) r.mode = MODE_LOAD;
      else if (pick < 90) r.mode = MODE_GEOMAG;
      else                r.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      r.quat_i = rand_quat();
      r.quat_j = rand_quat();
      r.quat_k = rand_quat();
      r.quat_real = rand_quat();
      r.gyro_y = 16'($urandom);
      r.gyro_z = 16'($urandom);
      r.report_status = 8'($urandom);
      // Now and then a trim outside the angle range, which the wrap must absorb.
      if ($urandom_range(0, 7) == 0) begin
         r.trim_pitch_in = 16'($urandom);
         r.trim_roll_in = 16'($urandom);
      end else begin
         r.trim_pitch_in = 16'($signed($urandom_range(0, 36000)) - 18000);
         r.trim_roll_in = 16'($signed($urandom_range(0, 36000)) - 18000);
      end
      return r;
   endfunction

   stim_row_type dir_tab [] = '{
      '{'{MODE_GEOMAG, -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384,
          16'sd32767, -16'sd32768, 8'hFF, 16'sd100, 16'sd100}, 1'b1, '0},
      '{'{MODE_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h00,
          16'sd18000, -16'sd18000}, 1'b1,
        '{16'd0, 16'd0, 16'd0, 20'd0, 2'd0, 1'b0, 16'd18000, 16'(-18000)}},
      '{'{MODE_ROT, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'hFF,
          16'sd0, 16'sd0}, 1'b1,
        '{16'd9000, 16'(-18000), 16'd0, 20'd0, 2'd3, 1'b0, 16'd18000, 16'(-18000)}},
      '{'{MODE_ZERO, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h00,
          16'sd0, 16'sd0}, 1'b1,
        '{16'd9000, 16'(-18000), 16'd0, 20'd0, 2'd3, 1'b0, 16'd18000, 16'(-18000)}},
      '{'{MODE_ROT, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h01,
          16'sd0, 16'sd0}, 1'b1,
        '{16'd9000, 16'd0, 16'd0, 20'd0, 2'd1, 1'b1, 16'd0, 16'(-18000)}},
      '{'{MODE_ROT, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 8'h02,
          16'sd0, 16'sd0}, 1'b0, '0},
      '{'{MODE_ROT, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h03,
          16'sd0, 16'sd0}, 1'b0, '0},
      '{'{MODE_ROT, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h00,
          16'sd0, 16'sd0}, 1'b0, '0},
      '{'{MODE_ROT, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 8'h00,
          16'sd0, 16'sd0}, 1'b0, '0},
      '{'{MODE_ROT, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 16'sd0, 16'sd0,
          8'hFC, 16'sd0, 16'sd0}, 1'b0, '0},
      // Pitch at the pole: the square root term is zero.
      '{'{MODE_ROT, 16'sd0, 16'sd8192, 16'sd0, 16'sd8192, 16'sd0, 16'sd0, 8'h01,
          16'sd0, 16'sd0}, 1'b0, '0},
      '{'{MODE_ROT, 16'sd8192, 16'sd0, 16'sd0, -16'sd8192, 16'sd0, 16'sd0, 8'h01,
          16'sd0, 16'sd0}, 1'b0, '0},
      '{'{MODE_GYRO, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd32767, 8'h00,
          16'sd0, 16'sd0}, 1'b0, '0},
      '{'{MODE_GYRO, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 8'h00,
          16'sd0, 16'sd0}, 1'b0, '0},
      '{'{MODE_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h00,
          16'sh7FFF, -16'sd32768}, 1'b0, '0},
      '{'{MODE_ROT, 16'sd3000, -16'sd5000, 16'sd7000, 16'sd11000, 16'sd0, 16'sd0, 8'h02,
          16'sd0, 16'sd0}, 1'b0, '0},
      '{'{MODE_SPARE_LO, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 8'h01,
          16'sd1, 16'sd1}, 1'b0, '0},
      '{'{3'd6, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h00,
          16'sd0, 16'sd0}, 1'b0, '0},
      '{'{MODE_SPARE_HI, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h00,
          16'sd0, 16'sd0}, 1'b0, '0},
      '{'{MODE_ZERO, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'h00,
          16'sd0, 16'sd0}, 1'b0, '0},
      '{'{MODE_ROT, -16'sd2000, 16'sd9000, 16'sd4000, 16'sd12000, 16'sd0, 16'sd0, 8'h03,
          16'sd0, 16'sd0}, 1'b0, '0},
      '{'{MODE_ROT, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 8'h00,
          16'sd0, 16'sd0}, 1'b0, '0}
   };

   // Response side: a random hold-off after each beat, and one long hold on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) stall_left = $urandom_range(0, 4);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      attitude_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.yaw_out, rsp_bus.pitch_out, rsp_bus.roll_out,
                 rsp_bus.yaw_rate_out, rsp_bus.accuracy_out, rsp_bus.trim_captured,
                 rsp_bus.trim_pitch_out, rsp_bus.trim_roll_out};
         if (pending_attitudes.size() == 0) begin
            errors++;
            $display("unexpected response beat at %0t", $realtime);
         end else begin
            want = pending_attitudes.pop_front();
            if (got !== want) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at %0t: yaw %0d/%0d pitch %0d/%0d roll %0d/%0d rate %0d/%0d acc %0d/%0d cap %0d/%0d trim %0d,%0d/%0d,%0d",
                     $realtime, want.yaw, got.yaw, $signed(want.pitch), $signed(got.pitch),
                     $signed(want.roll), $signed(got.roll), $signed(want.rate),
                     $signed(got.rate), want.acc, got.acc, want.captured, got.captured,
                     $signed(want.trim_pitch), $signed(want.trim_roll),
                     $signed(got.trim_pitch), $signed(got.trim_roll));
            end
         end
      end
   end

   initial begin
      int ph, n;
      errors = 0;
      mismatches = 0;
      long_hold_req = 1'b0;
      vertical = 1'b0;
      m_yaw = 0; m_pitch = 0; m_roll = 0; m_rate = 0;
      m_pitch_trim = 0; m_roll_trim = 0; m_acc = 2'd0; zero_armed = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_ROT;
      req_bus.quat_i = '0;
      req_bus.quat_j = '0;
      req_bus.quat_k = '0;
      req_bus.quat_real = '0;
      req_bus.gyro_y = '0;
      req_bus.gyro_z = '0;
      req_bus.report_status = '0;
      req_bus.trim_pitch_in = '0;
      req_bus.trim_roll_in = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) offer(dir_tab[i].rpt, dir_tab[i].typed, dir_tab[i].want);

      for (ph = 0; ph < 4; ph++) begin
         set_mount(ph[0] ? 1'b1 : 1'b0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Stall the response side long enough to back the queue up.
            if (ph == 1 && n == 40) long_hold_req = 1'b1;
            offer(rand_report(), 1'b0, '0);
         end
      end

      req_bus.valid <= 1'b0;
      while (pending_attitudes.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (errors == 0)
         $display("[quaternion_to_trimmed_euler_core] OK");
      else
         $display("[quaternion_to_trimmed_euler_core] ERROR");
      $finish;
   end

endmodule

// File: quaternion_to_trimmed_euler_core.f
rtl/qte_pkg.sv
rtl/qte_req_if.sv
rtl/qte_rsp_if.sv
rtl/qte_front.sv
rtl/qte_queue.sv
rtl/qte_back.sv
rtl/quaternion_to_trimmed_euler_core.sv
bench/quaternion_to_trimmed_euler_core_test.sv
